// ----- rtl/max_tree_area_opening_defines.svh -----
// Assertion macros shared by the checker.
`ifndef MAX_TREE_AREA_OPENING_DEFINES_SVH
`define MAX_TREE_AREA_OPENING_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define MTAO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define MTAO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mtao_pkg.sv -----
`default_nettype none
package mtao_pkg;

  localparam int IDX_W         = 12;
  localparam int AREA_W        = 13;
  localparam int IN_GREY_W     = 8;
  localparam int OUT_GREY_W    = 8;
  localparam int IN_DATA_W     = 48;
  localparam int OUT_DATA_W    = 24;
  localparam int DEF_MAX_NODES = 4096;
  localparam int DEF_GREY_BITS = 8;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic                  valid;
    logic [IDX_W-1:0]      index;
    logic [OUT_GREY_W-1:0] value;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/mtao_rec_mem.sv -----
`default_nettype none
// Node record memory: parent, area and grey value per node.
module mtao_rec_mem #(
  parameter int MAX_NODES = mtao_pkg::DEF_MAX_NODES,
  parameter int GREY_BITS = mtao_pkg::DEF_GREY_BITS,
  localparam int AW = $clog2(MAX_NODES)
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [mtao_pkg::IDX_W-1:0]    wr_parent,
  input  wire logic [mtao_pkg::AREA_W-1:0]   wr_area,
  input  wire logic [GREY_BITS-1:0]          wr_grey,
  input  wire logic [AW-1:0]                 rd_addr,
  output logic      [mtao_pkg::IDX_W-1:0]    rd_parent,
  output logic      [mtao_pkg::AREA_W-1:0]   rd_area,
  output logic      [GREY_BITS-1:0]          rd_grey
);

  localparam int REC_W = mtao_pkg::IDX_W + mtao_pkg::AREA_W + GREY_BITS;

  logic [REC_W-1:0] mem_r [MAX_NODES];
  logic [REC_W-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_parent, wr_area, wr_grey};
    end
    rd_q_r <= mem_r[rd_addr];
  end

  assign {rd_parent, rd_area, rd_grey} = rd_q_r;

endmodule
`default_nettype wire

// ----- rtl/mtao_mark_mem.sv -----
`default_nettype none
// Done mark and memoized result per node.
module mtao_mark_mem #(
  parameter int MAX_NODES = mtao_pkg::DEF_MAX_NODES,
  parameter int GREY_BITS = mtao_pkg::DEF_GREY_BITS,
  localparam int AW = $clog2(MAX_NODES)
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic                 wr_done,
  input  wire logic [GREY_BITS-1:0] wr_result,
  input  wire logic [AW-1:0]        rd_addr,
  output logic                      rd_done,
  output logic      [GREY_BITS-1:0] rd_result
);

  logic [GREY_BITS:0] mem_r [MAX_NODES];
  logic [GREY_BITS:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_done, wr_result};
    end
    rd_q_r <= mem_r[rd_addr];
  end

  assign {rd_done, rd_result} = rd_q_r;

endmodule
`default_nettype wire

// ----- rtl/mtao_walker.sv -----
`default_nettype none
// Sequencer: loads nodes, climbs the parent chain, then re-walks it to mark results.
module mtao_walker #(
  parameter int MAX_NODES = mtao_pkg::DEF_MAX_NODES,
  parameter int GREY_BITS = mtao_pkg::DEF_GREY_BITS,
  localparam int AW = $clog2(MAX_NODES)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_action,
  input  wire logic [mtao_pkg::IDX_W-1:0]     in_node,
  input  wire logic [mtao_pkg::IDX_W-1:0]     in_parent,
  input  wire logic [mtao_pkg::AREA_W-1:0]    in_area,
  input  wire logic [mtao_pkg::IN_GREY_W-1:0] in_grey,
  input  wire logic [mtao_pkg::AREA_W-1:0]    thr,
  output logic                                rec_we,
  output logic      [AW-1:0]                  rec_waddr,
  output logic      [mtao_pkg::IDX_W-1:0]     rec_wparent,
  output logic      [mtao_pkg::AREA_W-1:0]    rec_warea,
  output logic      [GREY_BITS-1:0]           rec_wgrey,
  output logic      [AW-1:0]                  rd_addr,
  input  wire logic [mtao_pkg::IDX_W-1:0]     rec_rparent,
  input  wire logic [mtao_pkg::AREA_W-1:0]    rec_rarea,
  input  wire logic [GREY_BITS-1:0]           rec_rgrey,
  output logic                                mk_we,
  output logic      [AW-1:0]                  mk_waddr,
  output logic                                mk_wdone,
  output logic      [GREY_BITS-1:0]           mk_wresult,
  input  wire logic                           mk_rdone,
  input  wire logic [GREY_BITS-1:0]           mk_rresult,
  output mtao_pkg::res_t                      res,
  input  wire logic                           res_ready
);

  localparam int          SW    = $clog2(MAX_NODES + 1);
  localparam logic [31:0] MAX_U = 32'(MAX_NODES);

  typedef enum logic [5:0] {
    ST_CLR   = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_FETCH = 6'b000100,
    ST_WALK  = 6'b001000,
    ST_MARK  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [AW-1:0]                clr_r, clr_nxt;
  logic [mtao_pkg::IDX_W-1:0]   node_r, node_nxt;
  logic [mtao_pkg::IDX_W-1:0]   cur_r, cur_nxt;
  logic [mtao_pkg::IDX_W-1:0]   par_r, par_nxt;
  logic [mtao_pkg::AREA_W-1:0]  area_r, area_nxt;
  logic [GREY_BITS-1:0]         grey_r, grey_nxt;
  logic                         cdone_r, cdone_nxt;
  logic [GREY_BITS-1:0]         cres_r, cres_nxt;
  logic [SW-1:0]                steps_r, steps_nxt;
  logic [GREY_BITS-1:0]         val_r, val_nxt;

  logic in_fire;
  logic in_range;
  logic par_ok;
  logic climb;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_range = 32'(in_node) < MAX_U;
  // parent neither self nor outside the tree
  assign par_ok   = (par_r != cur_r) && (32'(par_r) < MAX_U);
  assign climb    = !cdone_r && par_ok && (steps_r != SW'(MAX_NODES))
                    && ((grey_r == rec_rgrey) || (area_r <= thr));

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    node_nxt    = node_r;
    cur_nxt     = cur_r;
    par_nxt     = par_r;
    area_nxt    = area_r;
    grey_nxt    = grey_r;
    cdone_nxt   = cdone_r;
    cres_nxt    = cres_r;
    steps_nxt   = steps_r;
    val_nxt     = val_r;
    rec_we      = 1'b0;
    rec_waddr   = AW'(in_node);
    rec_wparent = in_parent;
    rec_warea   = in_area;
    rec_wgrey   = GREY_BITS'(in_grey);
    rd_addr     = AW'(in_node);
    mk_we       = 1'b0;
    mk_waddr    = AW'(in_node);
    mk_wdone    = 1'b0;
    mk_wresult  = '0;
    case (state_r)
      ST_CLR: begin
        mk_we    = 1'b1;
        mk_waddr = clr_r;
        clr_nxt  = clr_r + AW'(1);
        if (clr_r == AW'(MAX_NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          node_nxt  = in_node;
          steps_nxt = '0;
          if (in_action == mtao_pkg::ACT_LOAD) begin
            rec_we = in_range;
            mk_we  = in_range;
          end else if (in_range) begin
            state_nxt = ST_FETCH;
          end else begin
            val_nxt   = '0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_FETCH: begin
        cur_nxt   = node_r;
        par_nxt   = rec_rparent;
        area_nxt  = rec_rarea;
        grey_nxt  = rec_rgrey;
        cdone_nxt = mk_rdone;
        cres_nxt  = mk_rresult;
        rd_addr   = AW'(rec_rparent);
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        // read data holds the record of the current node's parent
        if (climb) begin
          cur_nxt   = par_r;
          par_nxt   = rec_rparent;
          area_nxt  = rec_rarea;
          grey_nxt  = rec_rgrey;
          cdone_nxt = mk_rdone;
          cres_nxt  = mk_rresult;
          steps_nxt = steps_r + SW'(1);
          rd_addr   = AW'(rec_rparent);
        end else begin
          if (cdone_r) begin
            val_nxt = cres_r;
          end else if (area_r > thr) begin
            val_nxt = grey_r;
          end else begin
            val_nxt = '0;
          end
          cur_nxt   = node_r;
          rd_addr   = AW'(node_r);
          state_nxt = ST_MARK;
        end
      end
      ST_MARK: begin
        // steps_r + 1 writes: every climbed node, then the stopping node
        mk_we      = 1'b1;
        mk_waddr   = AW'(cur_r);
        mk_wdone   = 1'b1;
        mk_wresult = val_r;
        cur_nxt    = rec_rparent;
        rd_addr    = AW'(rec_rparent);
        if (steps_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          steps_nxt = steps_r - SW'(1);
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  assign res.valid = (state_r == ST_DONE);
  assign res.index = node_r;
  assign res.value = mtao_pkg::OUT_GREY_W'(val_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    node_r  <= node_nxt;
    cur_r   <= cur_nxt;
    par_r   <= par_nxt;
    area_r  <= area_nxt;
    grey_r  <= grey_nxt;
    cdone_r <= cdone_nxt;
    cres_r  <= cres_nxt;
    steps_r <= steps_nxt;
    val_r   <= val_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/max_tree_area_opening.sv -----
// Max-tree area opening.
// in_*  : one item per handshake. in_tuser is the action (0 load node, 1 query node).
//         A load writes parent, area and grey value of one node and clears its done mark.
// out_* : one item per query: queried index and its area-opened grey value.
// cfg_* : writes the area threshold; take it only while no item is in flight.
// Load: written to both memories in the cycle it is taken. Query: S is the number of parent hops
// the climb takes; each hop is one read of the node record memory, once up the chain
// and once more to write the done marks back. Memoized marks keep S small on average.
// Items are handled one at a time. A finished result sits in the output register;
// new items are still taken while it waits, and a further query holds in its last
// state until the receiver frees the register.
// Reset: the done marks are swept clear, one node a cycle, over all MAX_NODES nodes, with
// in_tready low; configuration writes are taken throughout.
`default_nettype none
module max_tree_area_opening #(
  parameter int MAX_NODES = mtao_pkg::DEF_MAX_NODES,
  parameter int GREY_BITS = mtao_pkg::DEF_GREY_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // node_index, parent_index, node_area, grey_value
  input  wire logic [mtao_pkg::IN_DATA_W-1:0]      in_tdata,
  // action
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // result_index, filtered_value
  output logic      [mtao_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mtao_pkg::AREA_W-1:0]         cfg_data
);

  localparam int AW = $clog2(MAX_NODES);

  logic [mtao_pkg::IDX_W-1:0]     f_node, f_parent;
  logic [mtao_pkg::AREA_W-1:0]    f_area;
  logic [mtao_pkg::IN_GREY_W-1:0] f_grey;

  logic [mtao_pkg::AREA_W-1:0]    thr_r;
  logic                           out_valid_r;
  logic [mtao_pkg::IDX_W-1:0]     out_index_r;
  logic [mtao_pkg::OUT_GREY_W-1:0] out_value_r;

  logic                           rec_we, mk_we, mk_wdone, mk_rdone;
  logic [AW-1:0]                  rec_waddr, mk_waddr, rd_addr;
  logic [mtao_pkg::IDX_W-1:0]     rec_wparent, rec_rparent;
  logic [mtao_pkg::AREA_W-1:0]    rec_warea, rec_rarea;
  logic [GREY_BITS-1:0]           rec_wgrey, rec_rgrey, mk_wresult, mk_rresult;
  mtao_pkg::res_t                 res;
  logic                           res_ready;

  assign f_node   = in_tdata[11:0];
  assign f_parent = in_tdata[23:12];
  assign f_area   = in_tdata[36:24];
  assign f_grey   = in_tdata[44:37];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  mtao_walker #(
    .MAX_NODES(MAX_NODES),
    .GREY_BITS(GREY_BITS)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_action  (in_tuser),
    .in_node    (f_node),
    .in_parent  (f_parent),
    .in_area    (f_area),
    .in_grey    (f_grey),
    .thr        (thr_r),
    .rec_we     (rec_we),
    .rec_waddr  (rec_waddr),
    .rec_wparent(rec_wparent),
    .rec_warea  (rec_warea),
    .rec_wgrey  (rec_wgrey),
    .rd_addr    (rd_addr),
    .rec_rparent(rec_rparent),
    .rec_rarea  (rec_rarea),
    .rec_rgrey  (rec_rgrey),
    .mk_we      (mk_we),
    .mk_waddr   (mk_waddr),
    .mk_wdone   (mk_wdone),
    .mk_wresult (mk_wresult),
    .mk_rdone   (mk_rdone),
    .mk_rresult (mk_rresult),
    .res        (res),
    .res_ready  (res_ready)
  );

  mtao_rec_mem #(
    .MAX_NODES(MAX_NODES),
    .GREY_BITS(GREY_BITS)
  ) u_rec_mem (
    .clk      (clk),
    .wr_en    (rec_we),
    .wr_addr  (rec_waddr),
    .wr_parent(rec_wparent),
    .wr_area  (rec_warea),
    .wr_grey  (rec_wgrey),
    .rd_addr  (rd_addr),
    .rd_parent(rec_rparent),
    .rd_area  (rec_rarea),
    .rd_grey  (rec_rgrey)
  );

  mtao_mark_mem #(
    .MAX_NODES(MAX_NODES),
    .GREY_BITS(GREY_BITS)
  ) u_mark_mem (
    .clk      (clk),
    .wr_en    (mk_we),
    .wr_addr  (mk_waddr),
    .wr_done  (mk_wdone),
    .wr_result(mk_wresult),
    .rd_addr  (rd_addr),
    .rd_done  (mk_rdone),
    .rd_result(mk_rresult)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
    if (res_ready && res.valid) begin
      out_index_r <= res.index;
      out_value_r <= res.value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_value_r, out_index_r};

endmodule
`default_nettype wire

// ----- rtl/mtao_checker.sv -----
`default_nettype none
`include "max_tree_area_opening_defines.svh"
module mtao_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [mtao_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  `MTAO_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "out item dropped while stalled")
  `MTAO_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "out item changed while stalled")
  // no item yields a result in the cycle right after it is taken
  `MTAO_ASSERT_NEXT(a_no_early_result, in_fire && !out_tvalid, !out_tvalid, "result appeared too early")
  // a query keeps the block busy past the next edge
  `MTAO_ASSERT_NEXT(a_query_busy, in_fire && (in_tuser == mtao_pkg::ACT_QUERY), !in_tready, "item taken during a query")

endmodule

bind max_tree_area_opening mtao_checker u_mtao_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES      = mtao_pkg::DEF_MAX_NODES;
  localparam int QUIET_MAX  = 40000;
  localparam int PHASE_SIZE = 105;

  typedef struct {
    logic [mtao_pkg::IDX_W-1:0]      index;
    logic [mtao_pkg::OUT_GREY_W-1:0] value;
  } filtered_t;

  // Mirror of the node records plus the queue of filtered values still owed.
  class opening_scoreboard;
    bit [mtao_pkg::IDX_W-1:0]      parent_of [NODES];
    bit [mtao_pkg::AREA_W-1:0]     area_of   [NODES];
    bit [mtao_pkg::IN_GREY_W-1:0]  grey_of   [NODES];
    bit [mtao_pkg::OUT_GREY_W-1:0] memo_of   [NODES];
    bit                            done      [NODES];
    bit [mtao_pkg::AREA_W-1:0]     lambda;
    filtered_t                     filtered_due[$];
    int                            errors;

    function void set_lambda(logic [mtao_pkg::AREA_W-1:0] t);
      lambda = t;
    endfunction

    function int pending();
      return filtered_due.size();
    endfunction

    function void take_item(logic act, logic [mtao_pkg::IDX_W-1:0] node,
                            logic [mtao_pkg::IDX_W-1:0] parent,
                            logic [mtao_pkg::AREA_W-1:0] area,
                            logic [mtao_pkg::IN_GREY_W-1:0] grey);
      int unsigned stop, hops, cur, p;
      logic [mtao_pkg::OUT_GREY_W-1:0] val;
      filtered_t f;
      if (act == mtao_pkg::ACT_LOAD) begin
        parent_of[node] = parent;
        area_of[node]   = area;
        grey_of[node]   = grey;
        done[node]      = 1'b0;
        return;
      end
      stop = 32'(node);
      hops = 0;
      // climb while not done, not root, and same grey as parent or small enough
      while (hops < NODES) begin
        p = 32'(parent_of[stop]);
        if (p == stop || done[stop])
          break;
        if (grey_of[stop] != grey_of[p] && area_of[stop] > lambda)
          break;
        stop = p;
        hops++;
      end
      if (done[stop])
        val = memo_of[stop];
      else if (area_of[stop] > lambda)
        val = grey_of[stop];
      else
        val = '0;
      cur = 32'(node);
      for (int i = 0; i < hops; i++) begin
        memo_of[cur] = val;
        done[cur]    = 1'b1;
        cur          = 32'(parent_of[cur]);
      end
      memo_of[stop] = val;
      done[stop]    = 1'b1;
      f.index = node;
      f.value = val;
      filtered_due.push_back(f);
    endfunction

    function void check_filtered(logic [mtao_pkg::IDX_W-1:0] idx,
                                 logic [mtao_pkg::OUT_GREY_W-1:0] val);
      filtered_t f;
      if (filtered_due.size() == 0) begin
        $error("unexpected result item: result_index %0d filtered_value %0d", idx, val);
        errors++;
        return;
      end
      f = filtered_due.pop_front();
      if (idx !== f.index) begin
        $error("result_index: expected %0d, actual %0d", f.index, idx);
        errors++;
      end
      if (val !== f.value) begin
        $error("filtered_value: expected %0d, actual %0d", f.value, val);
        errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  // node_index, parent_index, node_area, grey_value
  logic [mtao_pkg::IN_DATA_W-1:0]  in_tdata;
  // action
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  // result_index, filtered_value
  logic [mtao_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [mtao_pkg::AREA_W-1:0]     cfg_data;

  max_tree_area_opening uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  opening_scoreboard sb = new();
  bit  calm;
  int  hold_left;
  int  quiet;
  int  sent;
  bit  loaded [NODES];
  int  loaded_list[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= mtao_pkg::ACT_LOAD;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // receiver: random back-pressure, or a long hold-off when asked
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 23);
      end
    end
  end

  // result check and watchdog, both on the falling edge
  initial begin
    forever begin
      @(negedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_filtered(out_tdata[mtao_pkg::IDX_W-1:0],
                          out_tdata[mtao_pkg::IDX_W +: mtao_pkg::OUT_GREY_W]);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_MAX) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  task automatic send_item(logic act, int node, int parent, int area, int grey);
    @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b0, grey[mtao_pkg::IN_GREY_W-1:0], area[mtao_pkg::AREA_W-1:0],
                  parent[mtao_pkg::IDX_W-1:0], node[mtao_pkg::IDX_W-1:0]};
    do @(negedge clk); while (!in_tready);
    sb.take_item(act, node[mtao_pkg::IDX_W-1:0], parent[mtao_pkg::IDX_W-1:0],
                 area[mtao_pkg::AREA_W-1:0], grey[mtao_pkg::IN_GREY_W-1:0]);
    sent++;
  endtask

  task automatic load_node(int node, int parent, int area, int grey);
    send_item(mtao_pkg::ACT_LOAD, node, parent, area, grey);
    if (!loaded[node]) begin
      loaded[node] = 1'b1;
      loaded_list.push_back(node);
    end
  endtask

  task automatic query_node(int node);
    send_item(mtao_pkg::ACT_QUERY, node, $urandom_range(0, NODES - 1),
              $urandom_range(0, 4096), $urandom_range(0, 255));
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 99) < 23) begin
      @(posedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    @(posedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_lambda(int t);
    drain();
    // loads give no result, so let the last one settle
    repeat (12) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= t[mtao_pkg::AREA_W-1:0];
    do @(negedge clk); while (!cfg_ready);
    sb.set_lambda(t[mtao_pkg::AREA_W-1:0]);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // a small well-formed max-tree, then queries on its nodes: areas shrink and grey rises toward the leaves
  task automatic grow_tree(int k);
    int tn[$], ta[$], tg[$];
    int n, j, a, g;
    n = $urandom_range(0, NODES - 1);
    a = ($urandom_range(0, 9) == 0) ? 4096 : $urandom_range(0, 4096);
    g = $urandom_range(0, 255);
    maybe_gap();
    load_node(n, n, a, g);
    tn.push_back(n); ta.push_back(a); tg.push_back(g);
    for (int i = 1; i < k; i++) begin
      j = $urandom_range(0, i - 1);
      n = $urandom_range(0, NODES - 1);
      a = $urandom_range(0, ta[j]);
      g = ($urandom_range(0, 9) < 3) ? tg[j] : tg[j] + $urandom_range(1, 40);
      if (g > 255)
        g = 255;
      maybe_gap();
      load_node(n, tn[j], a, g);
      tn.push_back(n); ta.push_back(a); tg.push_back(g);
    end
    repeat ($urandom_range(1, k + 1)) begin
      maybe_gap();
      query_node(tn[$urandom_range(0, k - 1)]);
    end
  endtask

  task automatic noise();
    int n;
    maybe_gap();
    if ($urandom_range(0, 1) == 0) begin
      n = $urandom_range(0, NODES - 1);
      load_node(n, ($urandom_range(0, 2) == 0) ? n : pick_loaded(), $urandom_range(0, 4096),
                $urandom_range(0, 255));
    end else begin
      query_node(pick_loaded());
    end
  endtask

  initial begin
    int lambdas[6];
    int phase_start;
    bit paused;
    calm      = 1'b0;
    hold_left = 0;
    quiet     = 0;
    sent      = 0;
    @(posedge rst_n);
    write_lambda(100);

    // directed: extremes, memo reuse, reload of a done node, a two-node cycle
    load_node(4095, 4095, 4096, 10);
    load_node(0, 4095, 50, 255);
    load_node(1, 0, 0, 255);
    load_node(2, 4095, 200, 20);
    load_node(3, 2, 5, 20);
    load_node(4, 2, 150, 30);
    load_node(7, 2, 3000, 20);
    query_node(1);
    query_node(0);
    query_node(4095);
    query_node(3);
    query_node(4);
    query_node(2);
    query_node(4);
    query_node(7);
    load_node(0, 4095, 4096, 255);
    query_node(0);
    query_node(1);
    load_node(6, 6, 0, 7);
    load_node(5, 6, 0, 7);
    load_node(6, 5, 0, 7);
    query_node(5);
    query_node(6);

    lambdas = '{4096, 0, $urandom_range(1, 4095), $urandom_range(0, 64),
                $urandom_range(500, 4000), 4096};
    paused = 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      write_lambda(lambdas[ph]);
      calm = (ph == 2);
      if (ph == 3)
        hold_left = 400;
      phase_start = sent;
      while (sent - phase_start < PHASE_SIZE) begin
        if ($urandom_range(0, 99) < 80)
          grow_tree($urandom_range(2, 10));
        else
          noise();
        if (ph == 4 && !paused && sent - phase_start >= 50) begin
          paused = 1'b1;
          drain();
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/mtao_pkg.sv
rtl/mtao_rec_mem.sv
rtl/mtao_mark_mem.sv
rtl/mtao_walker.sv
rtl/max_tree_area_opening.sv
rtl/mtao_checker.sv
dv/testbench.sv
